>>> design/blowfish_block_encrypt_defines.svh
// ----------------------------------------------------------------------------
// Blowfish block encrypt assertion macros
// Shared concurrent checks; each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef BLOWFISH_BLOCK_ENCRYPT_DEFINES_SVH
`define BLOWFISH_BLOCK_ENCRYPT_DEFINES_SVH

// Condition holds at every edge out of reset.
`define BFE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BFE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bfe_pkg.sv
// ----------------------------------------------------------------------------
// Blowfish block encrypt package
// Item types, command encoding and table geometry shared across the design.
// ----------------------------------------------------------------------------
`default_nettype none

package bfe_pkg;

  localparam int WORD_W          = 32;
  localparam int BYTE_W          = 8;
  localparam int INDEX_W         = 10;
  localparam int KIND_W          = 2;
  localparam int SUBKEY_WORDS    = 18;
  localparam int SBOX_WORDS      = 1024;
  localparam int SBOX_BANK_WORDS = 256;
  localparam int SBOX_BANKS      = SBOX_WORDS / SBOX_BANK_WORDS;
  localparam int BANK_ADDR_W     = $clog2(SBOX_BANK_WORDS);
  localparam int BANK_SEL_W      = $clog2(SBOX_BANKS);
  localparam int SUBKEY_IDX_W    = $clog2(SUBKEY_WORDS);
  localparam int ROUND_COUNT     = 16;
  localparam int STEP_W          = $clog2(ROUND_COUNT);

  // Input item kind codes
  localparam logic [KIND_W-1:0] KIND_LOAD_SUBKEY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_SBOX   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ENCRYPT     = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] table_index;
    logic [WORD_W-1:0]  load_word;
    logic [WORD_W-1:0]  left_in;
    logic [WORD_W-1:0]  right_in;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] left_out;
    logic [WORD_W-1:0] right_out;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_LOAD_SUBKEY = 2'd0,
    CMD_LOAD_SBOX   = 2'd1,
    CMD_ENCRYPT     = 2'd2
  } cmd_op_t;

  // Classified work handed from front to back
  typedef struct packed {
    cmd_op_t            op;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  left;
    logic [WORD_W-1:0]  right;
  } cmd_t;

endpackage

`default_nettype wire

>>> design/blowfish_block_encrypt.sv
// ----------------------------------------------------------------------------
// Blowfish block encrypt
// Subkey and S-box loads plus 16-round Blowfish block encryption.
// ----------------------------------------------------------------------------
//   channel   handshake          payload
//   input     start / busy       in_item  (kind, table_index, load_word, halves)
//   result    out_strobe         out_item (left_out, right_out)
//
// An encrypt item runs in the back end as: dequeue, then for each of the
// 16 rounds an S-box read then a mix and swap, then whitening; the registered
// S-box RAM read splits each round into these steps. Loads finish at dequeue.
// Items are queued (registered) before dequeue; busy is high while it is full.
// Reset (synchronous, rst_n low) empties the queue and idles the back end;
// table contents are not cleared. The result strobe lasts one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module blowfish_block_encrypt #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire bfe_pkg::in_item_t  in_item,
  output logic                    out_strobe,
  output bfe_pkg::out_item_t      out_item
);

  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  bfe_pkg::cmd_t push_cmd;
  bfe_pkg::cmd_t head_cmd;

  assign busy = full;

  bfe_front u_front (
    .start    (start),
    .full_i   (full),
    .in_item_i(in_item),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  bfe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .full_o (full),
    .empty_o(empty)
  );

  bfe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty_i     (empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_strobe_o(out_strobe),
    .out_item_o  (out_item)
  );

endmodule

`default_nettype wire

>>> design/bfe_front.sv
// ----------------------------------------------------------------------------
// Blowfish front end
// Accepts input items, drops the ones with no effect, queues the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module bfe_front (
  input  wire logic             start,
  input  wire logic             full_i,
  input  wire bfe_pkg::in_item_t in_item_i,
  output logic                  push_o,
  output bfe_pkg::cmd_t         cmd_o
);

  logic keep;

  always_comb begin
    cmd_o.index = in_item_i.table_index;
    cmd_o.word  = in_item_i.load_word;
    cmd_o.left  = in_item_i.left_in;
    cmd_o.right = in_item_i.right_in;
    cmd_o.op    = bfe_pkg::CMD_ENCRYPT;
    keep        = 1'b0;
    unique case (in_item_i.kind)
      bfe_pkg::KIND_LOAD_SUBKEY: begin
        // drop subkey writes past the end of the array
        cmd_o.op = bfe_pkg::CMD_LOAD_SUBKEY;
        keep     = (in_item_i.table_index < bfe_pkg::INDEX_W'(bfe_pkg::SUBKEY_WORDS));
      end
      bfe_pkg::KIND_LOAD_SBOX: begin
        cmd_o.op = bfe_pkg::CMD_LOAD_SBOX;
        keep     = 1'b1;
      end
      bfe_pkg::KIND_ENCRYPT: begin
        cmd_o.op = bfe_pkg::CMD_ENCRYPT;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = start && !full_i && keep;

endmodule

`default_nettype wire

>>> design/bfe_queue.sv
// ----------------------------------------------------------------------------
// Blowfish command queue
// Small FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
`include "blowfish_block_encrypt_defines.svh"

module bfe_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_i,
  input  wire bfe_pkg::cmd_t cmd_i,
  input  wire logic          pop_i,
  output bfe_pkg::cmd_t      head_o,
  output logic               full_o,
  output logic               empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bfe_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign empty_o = (count_r == '0);
  assign head_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= cmd_i;
    end
  end

  `BFE_ASSERT_IMPLIES(a_no_push_full, full_o, !push_i, "queue push while full")
  `BFE_ASSERT_IMPLIES(a_no_pop_empty, empty_o, !pop_i, "queue pop while empty")

endmodule

`default_nettype wire

>>> design/bfe_ram.sv
// ----------------------------------------------------------------------------
// Blowfish generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

>>> design/bfe_back.sv
// ----------------------------------------------------------------------------
// Blowfish back end
// Executes table loads and runs the 16 Feistel rounds, each a read then a mix.
// ----------------------------------------------------------------------------
`default_nettype none
`include "blowfish_block_encrypt_defines.svh"

module bfe_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          empty_i,
  input  wire bfe_pkg::cmd_t cmd_i,
  output logic               pop_o,
  output logic               out_strobe_o,
  output bfe_pkg::out_item_t out_item_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ADDR = 4'b0010,
    ST_MIX  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [bfe_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [bfe_pkg::WORD_W-1:0]     a_r, a_nxt;
  logic [bfe_pkg::WORD_W-1:0]     b_r, b_nxt;
  logic [bfe_pkg::WORD_W-1:0]     subkey_r [bfe_pkg::SUBKEY_WORDS];
  logic                           out_strobe_r, out_strobe_nxt;
  bfe_pkg::out_item_t             out_item_r, out_item_nxt;

  logic [bfe_pkg::WORD_W-1:0]     x_half;
  logic [bfe_pkg::WORD_W-1:0]     f_val;
  logic [bfe_pkg::WORD_W-1:0]     sbox_q [bfe_pkg::SBOX_BANKS];
  logic                           load_sbox;
  logic                           load_subkey;

  assign pop_o        = (state_r == ST_IDLE) && !empty_i;
  assign load_sbox    = pop_o && (cmd_i.op == bfe_pkg::CMD_LOAD_SBOX);
  assign load_subkey  = pop_o && (cmd_i.op == bfe_pkg::CMD_LOAD_SUBKEY);
  assign out_strobe_o = out_strobe_r;
  assign out_item_o   = out_item_r;

  // Whitened half for this step; its bytes address the four S-box banks
  assign x_half = a_r ^ subkey_r[bfe_pkg::SUBKEY_IDX_W'(step_r)];

  for (genvar k = 0; k < bfe_pkg::SBOX_BANKS; k++) begin : g_sbox
    bfe_ram #(
      .WIDTH(bfe_pkg::WORD_W),
      .DEPTH(bfe_pkg::SBOX_BANK_WORDS)
    ) u_sbox (
      .clk  (clk),
      .we   (load_sbox &&
             (cmd_i.index[bfe_pkg::INDEX_W-1 -: bfe_pkg::BANK_SEL_W] ==
              bfe_pkg::BANK_SEL_W'(k))),
      .waddr(cmd_i.index[bfe_pkg::BANK_ADDR_W-1:0]),
      .wdata(cmd_i.word),
      .raddr(x_half[bfe_pkg::WORD_W-1-k*bfe_pkg::BYTE_W -: bfe_pkg::BYTE_W]),
      .rdata(sbox_q[k])
    );
  end

  assign f_val = ((sbox_q[0] + sbox_q[1]) ^ sbox_q[2]) + sbox_q[3];

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_o && (cmd_i.op == bfe_pkg::CMD_ENCRYPT)) begin
          a_nxt     = cmd_i.left;
          b_nxt     = cmd_i.right;
          step_nxt  = '0;
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        // hold the whitened half while the S-box reads complete
        a_nxt     = x_half;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        // mix into the other half and swap
        a_nxt    = b_r ^ f_val;
        b_nxt    = a_r;
        step_nxt = step_r + 1'b1;
        if (step_r == bfe_pkg::STEP_W'(bfe_pkg::ROUND_COUNT - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_ADDR;
        end
      end
      ST_FIN: begin
        out_item_nxt.left_out  = b_r ^ subkey_r[bfe_pkg::SUBKEY_WORDS - 1];
        out_item_nxt.right_out = a_r ^ subkey_r[bfe_pkg::SUBKEY_WORDS - 2];
        out_strobe_nxt         = 1'b1;
        state_nxt              = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    out_item_r <= out_item_nxt;
    if (load_subkey) begin
      subkey_r[cmd_i.index[bfe_pkg::SUBKEY_IDX_W-1:0]] <= cmd_i.word;
    end
  end

  `BFE_ASSERT_NEXT(a_strobe_single, out_strobe_r, !out_strobe_r, "strobe over one cycle")
  `BFE_ASSERT_IMPLIES(a_strobe_after_fin, out_strobe_r, $past(state_r) == ST_FIN, "no finish step")
  `BFE_ASSERT_IMPLIES(a_mix_after_addr, state_r == ST_MIX, $past(state_r) == ST_ADDR, "no read step")

endmodule

`default_nettype wire

>>> verif/tb_blowfish_block_encrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blowfish block encrypt testbench
// Fills the subkey and S-box tables, then runs directed and random loads and
// encrypts through the start/busy port. A local cipher model predicts each
// ciphertext at acceptance, and the monitor checks every strobed result.
// ----------------------------------------------------------------------------

module tb_blowfish_block_encrypt;

  localparam logic [bfe_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int MAX_REPORTS   = 25;
  localparam int PHASE_ITEMS   = 240;

  typedef struct {
    bfe_pkg::in_item_t item;
    int unsigned       idle_pct;
  } pending_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  bfe_pkg::in_item_t  in_item = '0;
  logic               busy;
  logic               out_strobe;
  bfe_pkg::out_item_t out_item;

  pending_t           pending_q[$];
  bfe_pkg::out_item_t cipher_q[$];
  logic [31:0]        subkey_m[bfe_pkg::SUBKEY_WORDS];
  logic [31:0]        sbox_m[bfe_pkg::SBOX_WORDS];
  bit                 item_taken = 1'b0;

  int unsigned err_count = 0;
  int unsigned n_encrypt = 0;
  int unsigned n_load = 0;
  int unsigned n_ignored = 0;
  int unsigned n_checked = 0;

  blowfish_block_encrypt DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // F: two adds and a xor over one word from each S-box bank
  function automatic logic [31:0] sbox_mix(input logic [31:0] x);
    logic [31:0] a, b, c, d;
    a = sbox_m[x[31:24]];
    b = sbox_m[bfe_pkg::SBOX_BANK_WORDS + x[23:16]];
    c = sbox_m[2 * bfe_pkg::SBOX_BANK_WORDS + x[15:8]];
    d = sbox_m[3 * bfe_pkg::SBOX_BANK_WORDS + x[7:0]];
    return ((a + b) ^ c) + d;
  endfunction

  function automatic bfe_pkg::out_item_t encipher(input logic [31:0] left,
                                                  input logic [31:0] right);
    logic [31:0]        l, r;
    bfe_pkg::out_item_t res;
    l = left;
    r = right;
    for (int i = 0; i < bfe_pkg::ROUND_COUNT; i += 2) begin
      l ^= subkey_m[i];
      r ^= sbox_mix(l);
      r ^= subkey_m[i + 1];
      l ^= sbox_mix(r);
    end
    // final swap folded into the whitening
    res.left_out  = r ^ subkey_m[17];
    res.right_out = l ^ subkey_m[16];
    return res;
  endfunction

  // Update the tables or compute the ciphertext for one accepted item
  task automatic track_item(input bfe_pkg::in_item_t it, output bit made,
                            output bfe_pkg::out_item_t res);
    made = 1'b0;
    res  = '0;
    case (it.kind)
      bfe_pkg::KIND_LOAD_SUBKEY: begin
        if (it.table_index < bfe_pkg::SUBKEY_WORDS) begin
          subkey_m[it.table_index] = it.load_word;
          n_load++;
        end else begin
          n_ignored++;
        end
      end
      bfe_pkg::KIND_LOAD_SBOX: begin
        sbox_m[it.table_index] = it.load_word;
        n_load++;
      end
      bfe_pkg::KIND_ENCRYPT: begin
        res  = encipher(it.left_in, it.right_in);
        made = 1'b1;
        n_encrypt++;
      end
      default: n_ignored++;
    endcase
  endtask

  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return 32'h0000_0000;
    if (r < 16) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic queue_item(input logic [bfe_pkg::KIND_W-1:0] kind, input int unsigned idx,
                            input logic [31:0] word, input logic [31:0] l,
                            input logic [31:0] r, input int unsigned pct);
    pending_t p;
    p.item.kind        = kind;
    p.item.table_index = idx[bfe_pkg::INDEX_W-1:0];
    p.item.load_word   = word;
    p.item.left_in     = l;
    p.item.right_in    = r;
    p.idle_pct         = pct;
    pending_q.push_back(p);
  endtask

  // Driver: hold the item until taken, then present the next or idle with noise
  always @(negedge clk) begin : driver
    pending_t     nxt;
    logic [127:0] noise;
    if (rst_n && !(start && !item_taken)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= pending_q[0].idle_pct) begin
        nxt = pending_q.pop_front();
        in_item <= nxt.item;
        start   <= 1'b1;
      end else begin
        noise = {$urandom, $urandom, $urandom, $urandom};
        in_item <= noise[$bits(bfe_pkg::in_item_t)-1:0];
        start   <= 1'b0;
      end
    end
  end

  // Monitor: check strobed results, then record the item accepted at this edge
  always @(posedge clk) begin : monitor
    bfe_pkg::out_item_t want;
    bfe_pkg::out_item_t fresh;
    bit                 made;
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      if (out_strobe !== 1'b0) begin
        if (cipher_q.size() == 0) begin
          report_mismatch($sformatf("result %h_%h with nothing expected",
                                    out_item.left_out, out_item.right_out));
        end else begin
          want = cipher_q.pop_front();
          n_checked++;
          if (out_item.left_out !== want.left_out) begin
            report_mismatch($sformatf("left_out %h, expected %h",
                                      out_item.left_out, want.left_out));
          end
          if (out_item.right_out !== want.right_out) begin
            report_mismatch($sformatf("right_out %h, expected %h",
                                      out_item.right_out, want.right_out));
          end
        end
      end
      item_taken <= start && !busy;
      if (start && !busy) begin
        track_item(in_item, made, fresh);
        if (made) cipher_q.push_back(fresh);
      end
    end
  end

  initial begin : stimulus
    int unsigned pct_list[4];
    int unsigned count;
    int unsigned r;
    pct_list = '{0, 50, 0, 36};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every entry is written before the first encrypt reads it
    for (int i = 0; i < bfe_pkg::SUBKEY_WORDS; i++) begin
      queue_item(bfe_pkg::KIND_LOAD_SUBKEY, i, pick_word(), $urandom, $urandom, 0);
    end
    for (int i = 0; i < bfe_pkg::SBOX_WORDS; i++) begin
      queue_item(bfe_pkg::KIND_LOAD_SBOX, i, pick_word(), $urandom, $urandom, 0);
    end

    // Directed: extreme halves and words, bank edges, ignored items
    queue_item(bfe_pkg::KIND_ENCRYPT, $urandom, $urandom, 32'h0, 32'h0, 0);
    queue_item(bfe_pkg::KIND_ENCRYPT, $urandom, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    queue_item(bfe_pkg::KIND_ENCRYPT, 10'h3FF, 32'hFFFF_FFFF, 32'h5555_5555,
               32'hAAAA_AAAA, 0);
    queue_item(bfe_pkg::KIND_LOAD_SUBKEY, 0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    queue_item(bfe_pkg::KIND_LOAD_SUBKEY, 17, 32'hFFFF_FFFF, 32'h0, 32'h0, 0);
    queue_item(bfe_pkg::KIND_LOAD_SUBKEY, 18, $urandom, $urandom, $urandom, 0);
    queue_item(bfe_pkg::KIND_LOAD_SUBKEY, 1023, $urandom, $urandom, $urandom, 0);
    queue_item(bfe_pkg::KIND_ENCRYPT, 0, 0, 32'hAAAA_AAAA, 32'h5555_5555, 0);
    queue_item(bfe_pkg::KIND_LOAD_SBOX, 0, 32'h0, $urandom, $urandom, 0);
    queue_item(bfe_pkg::KIND_LOAD_SBOX, 255, 32'hFFFF_FFFF, $urandom, $urandom, 0);
    queue_item(bfe_pkg::KIND_LOAD_SBOX, 256, $urandom, $urandom, $urandom, 0);
    queue_item(bfe_pkg::KIND_LOAD_SBOX, 511, $urandom, $urandom, $urandom, 0);
    queue_item(bfe_pkg::KIND_LOAD_SBOX, 512, $urandom, $urandom, $urandom, 0);
    queue_item(bfe_pkg::KIND_LOAD_SBOX, 767, $urandom, $urandom, $urandom, 0);
    queue_item(bfe_pkg::KIND_LOAD_SBOX, 768, $urandom, $urandom, $urandom, 0);
    queue_item(bfe_pkg::KIND_LOAD_SBOX, 1023, 32'hFFFF_FFFF, $urandom, $urandom, 0);
    queue_item(bfe_pkg::KIND_ENCRYPT, $urandom, $urandom, 32'h00FF_00FF, 32'hFF00_FF00, 0);
    queue_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, 0);
    queue_item(KIND_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    // reload a word then encrypt right behind it
    queue_item(bfe_pkg::KIND_LOAD_SBOX, 768, $urandom, $urandom, $urandom, 0);
    queue_item(bfe_pkg::KIND_ENCRYPT, $urandom, $urandom, 32'h0, 32'h0, 0);

    // Random: mostly encrypts, with loads that rewrite the tables mid-stream
    foreach (pct_list[ph]) begin
      count = 0;
      while (count < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 60) begin
          queue_item(bfe_pkg::KIND_ENCRYPT, $urandom, $urandom, pick_word(), pick_word(),
                     pct_list[ph]);
        end else if (r < 80) begin
          queue_item(bfe_pkg::KIND_LOAD_SBOX, $urandom_range(bfe_pkg::SBOX_WORDS - 1),
                     pick_word(), $urandom, $urandom, pct_list[ph]);
        end else if (r < 92) begin
          queue_item(bfe_pkg::KIND_LOAD_SUBKEY, $urandom_range(bfe_pkg::SUBKEY_WORDS - 1),
                     pick_word(), $urandom, $urandom, pct_list[ph]);
        end else if (r < 97) begin
          queue_item(bfe_pkg::KIND_LOAD_SUBKEY,
                     $urandom_range(1023, bfe_pkg::SUBKEY_WORDS), $urandom,
                     $urandom, $urandom, pct_list[ph]);
        end else begin
          // ignored kind: does not advance the item count
          queue_item(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom, pct_list[ph]);
          count--;
        end
        count++;
      end
    end

    while (pending_q.size() != 0 || start) @(posedge clk);
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d table loads, %0d ignored items and %0d encrypts,",
             n_load, n_ignored, n_encrypt);
    $display("with %0d ciphertexts checked and %0d mismatches.", n_checked, err_count);
    if (err_count == 0 && n_checked == n_encrypt) begin
      $display("** blowfish_block_encrypt: PASSED **");
    end else begin
      $display("** blowfish_block_encrypt: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("Timeout: stimulus or results stalled");
    $display("** blowfish_block_encrypt: FAILED **");
    $finish;
  end

endmodule
